>>> rtl/sftm_pkg.sv
// Shared types and constants for the sparse fiber times matrix block.
// Used by sftm_ctrl, sftm_dp and the top level; depends on nothing.
package sftm_pkg;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 4;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 40;
    localparam int CFG_W   = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFG_W-1:0] CFG_COLS_RESET = 5'd16;

    // tuser codes on the input channel
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NZ   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic wr_mem;    // write the matrix entry carried by the input request
        logic take_nz;   // capture a nonzero's row and value
        logic cnt_clr;   // column counter back to zero
        logic mac_go;    // issue one column into the multiply-accumulate pipe
        logic emit_go;   // move one accumulator into the output register
        logic acc_clr;   // drop all accumulators to zero
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_op;
        logic in_last;
        logic in_row_ok;
        logic cnt_at_end;
        logic pipe_idle;
        logic out_room;
    } t_sts;

endpackage

>>> rtl/sftm_ctrl.sv
// Controller state machine for the sparse fiber times matrix block.
// Depends on sftm_pkg; drives sftm_dp through t_cmd and reads t_sts.
module sftm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  sftm_pkg::t_sts i_sts,
    output sftm_pkg::t_cmd o_cmd
);
    import sftm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_fiber_end, n_fiber_end;
    logic   accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state     = r_state;
        n_fiber_end = r_fiber_end;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.in_op == OP_LOAD) begin
                        o_cmd.wr_mem = 1'b1;
                    end else begin
                        o_cmd.take_nz = 1'b1;
                        o_cmd.cnt_clr = 1'b1;
                        n_fiber_end   = i_sts.in_last;
                        if (i_sts.in_row_ok) begin
                            n_state = S_MAC;
                        end else if (i_sts.in_last) begin
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_MAC: begin
                o_cmd.mac_go = 1'b1;
                if (i_sts.cnt_at_end) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = r_fiber_end ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_idle) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_room) begin
                    o_cmd.emit_go = 1'b1;
                    if (i_sts.cnt_at_end) begin
                        o_cmd.acc_clr = 1'b1;
                        o_cmd.cnt_clr = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fiber_end <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fiber_end <= n_fiber_end;
        end
    end

endmodule

>>> rtl/sftm_dp.sv
// Datapath: matrix store, column counter, multiply-accumulate pipe,
// column accumulators and output register. Depends on sftm_pkg.
module sftm_dp #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sftm_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic [sftm_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  logic                                 i_s_tuser,
    input  logic                                 i_s_tlast,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [sftm_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                 o_m_tlast,
    input  sftm_pkg::t_cmd                       i_cmd,
    output sftm_pkg::t_sts                       o_sts
);
    import sftm_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // input fields
    logic [ROW_W-1:0]        in_row;
    logic [COL_W-1:0]        in_col;
    logic signed [VAL_W-1:0] in_val;
    logic                    in_load_ok;
    logic [AW-1:0]           wr_addr;

    assign in_row = i_s_tdata[ROW_W-1:0];
    assign in_col = i_s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_val = i_s_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];

    assign o_sts.in_op     = i_s_tuser;
    assign o_sts.in_last   = i_s_tlast;
    assign o_sts.in_row_ok = (32'(in_row) < MAX_ROWS);
    assign in_load_ok      = o_sts.in_row_ok && (32'(in_col) < MAX_COLS);
    assign wr_addr = AW'(32'(in_row) * 32'(MAX_COLS) + 32'(in_col));

    // column count register; its value is clamped to 1..MAX_COLS where used
    logic [CFG_W-1:0] r_cfg_cols;
    logic [CW-1:0]    n_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= CFG_COLS_RESET;
        end else if (i_cfg_we) begin
            r_cfg_cols <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_cfg_cols == '0) begin
            n_cols = CW'(1);
        end else if (32'(r_cfg_cols) > MAX_COLS) begin
            n_cols = CW'(MAX_COLS);
        end else begin
            n_cols = CW'(r_cfg_cols);
        end
    end

    // captured nonzero and column counter
    logic [ROW_W-1:0]        r_row;
    logic signed [VAL_W-1:0] r_val;
    logic [CIW-1:0]          r_cnt;
    logic [AW-1:0]           rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_nz) begin
            r_row <= in_row;
            r_val <= in_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.mac_go || i_cmd.emit_go) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_sts.cnt_at_end = (32'(r_cnt) + 32'd1 == 32'(n_cols));
    assign rd_addr = AW'(32'(r_row) * 32'(MAX_COLS) + 32'(r_cnt));

    // matrix store, one write and one registered read port
    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_mem && in_load_ok) begin
            r_mem[wr_addr] <= in_val;
        end
        if (i_cmd.mac_go) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // pipe: read -> product -> accumulate
    logic                     r_s1_vld, r_s2_vld;
    logic [CIW-1:0]           r_s1_col, r_s2_col;
    logic signed [VAL_W-1:0]  r_s1_val;
    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.mac_go;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_go) begin
            r_s1_col <= r_cnt;
            r_s1_val <= r_val;
        end
        if (r_s1_vld) begin
            r_s2_col <= r_s1_col;
            r_prod   <= r_s1_val * r_rd_data;
        end
    end

    assign o_sts.pipe_idle = !r_s1_vld && !r_s2_vld;

    // column accumulators; an entry without its valid bit reads as zero
    logic signed [SUM_W-1:0] r_acc [MAX_COLS];
    logic [MAX_COLS-1:0]     r_acc_vld;
    logic [CIW-1:0]          acc_col;
    logic signed [SUM_W-1:0] acc_cur;
    logic signed [SUM_W:0]   acc_sum;
    logic signed [SUM_W-1:0] acc_sat;

    assign acc_col = i_cmd.emit_go ? r_cnt : r_s2_col;
    assign acc_cur = r_acc_vld[acc_col] ? r_acc[acc_col] : '0;
    assign acc_sum = (SUM_W+1)'(acc_cur) + (SUM_W+1)'(r_prod);

    always_comb begin
        if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
            acc_sat = acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            acc_sat = acc_sum[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (i_cmd.acc_clr) begin
            r_acc_vld <= '0;
        end else if (r_s2_vld) begin
            r_acc_vld[r_s2_col] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_acc[r_s2_col] <= acc_sat;
        end
    end

    // output register
    logic                    r_out_vld;
    logic [COL_W-1:0]        r_out_col;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_last;

    assign o_sts.out_room = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_go) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_go) begin
            r_out_col  <= COL_W'(r_cnt);
            r_out_sum  <= acc_cur;
            r_out_last <= o_sts.cnt_at_end;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OUT_TDATA_W-SUM_W-COL_W){1'b0}}, r_out_sum, r_out_col};
    assign o_m_tlast  = r_out_last;

endmodule

>>> rtl/sparse_fiber_times_matrix.sv
// Sparse tensor fiber times dense matrix (Q8.8 in, Q24.16 saturated out).
// Matrix load: accepted while idle. Nonzero: accepted, then swept over the
// N columns in use through the single shared multiply-accumulate unit.
// Last nonzero of a fiber: the MAC pipe drains, then the N accumulators are
// emitted, one result per cycle while the sink keeps up.
// Reset (sync, active low) clears control state, accumulators and sets 16 columns.
module sparse_fiber_times_matrix #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: columns in use
    input  logic                               i_cfg_we,
    input  logic [sftm_pkg::CFG_W-1:0]         i_cfg_wdata,
    // input requests
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] row_index, [11:8] col_index, [27:12] value, [31:28] zero
    input  logic [sftm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] op: 0 matrix load, 1 tensor nonzero
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,   // last_in_fiber
    // result requests
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [3:0] out_col, [43:4] out_sum, [47:44] zero
    output logic [sftm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast    // out_last
);
    import sftm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller sequences: accept -> MAC sweep over columns -> (on fiber end)
    // pipe drain -> emit sweep that also clears the accumulators.
    sftm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath holds the matrix store, MAC pipe, accumulators and the output
    // register; input requests wait while an emit sweep is held up by a pending result.
    sftm_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tlast   (s_axis_tlast),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // emit must never overtake an accumulation still in flight
    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_go |-> sts.pipe_idle)
        else $error("emit issued while MAC pipe busy");

    // MAC sweep and emit sweep share the column counter
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mac_go && cmd.emit_go))
        else $error("MAC and emit issued together");

    // finishing an emit sweep returns the block to taking requests
    a_ready_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_go && sts.cnt_at_end) |=> s_axis_tready)
        else $error("not ready after last emitted column");

    // the last column carries the last mark into the output register
    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_go && sts.cnt_at_end) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("final column without last mark");

endmodule

>>> sim/tb_sparse_fiber_times_matrix.sv
`timescale 1ns / 1ps
// Self-checking bench for sparse_fiber_times_matrix: matrix loads, fibers of nonzeros,
// column-count settings, large sums and output backpressure, checked by a built-in predictor.
// Depends on sftm_pkg and the block's RTL; reads no files.
module tb_sparse_fiber_times_matrix;
    import sftm_pkg::*;

    localparam int ROWS             = 256;
    localparam int COLS             = 16;
    localparam int DRAIN_CYCLES     = 64;      // well above a full-width MAC sweep plus pipe drain
    localparam int SINK_HOLD_CYCLES = 400;     // long enough to back the block up
    localparam int CYCLE_LIMIT      = 400000;
    localparam int IDLE_PCT         = 18;
    localparam int RANDOM_ITEMS     = 48;

    localparam logic [VAL_W-1:0] VAL_MAX = 16'h7FFF;   // +127.996 in Q8.8
    localparam logic [VAL_W-1:0] VAL_MIN = 16'h8000;   // -128.0 in Q8.8
    localparam longint SUM_HI = 64'sd549755813887;     // 2^39 - 1
    localparam longint SUM_LO = -64'sd549755813888;    // -2^39

    // one column of an emitted output fiber
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [SUM_W-1:0] sum;
        logic             last;
    } t_col_result;

    // ------------------------------------------------------------------
    // DUT ports; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [7:0] row_index, [11:8] col_index, [27:12] value, [31:28] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [0] op
    logic                   s_axis_tuser  = 1'b0;
    logic                   s_axis_tlast  = 1'b0;    // last_in_fiber
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [3:0] out_col, [43:4] out_sum, [47:44] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;            // out_last

    // ------------------------------------------------------------------
    // Predictor state: matrix copy, per-column accumulators, column count
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] mat_entry   [ROWS][COLS];
    bit               mat_written [ROWS][COLS];      // never read an unwritten entry
    longint           col_acc     [COLS] = '{default: 0};
    logic [CFG_W-1:0] cols_reg    = CFG_COLS_RESET;
    t_col_result      pending_cols [$];              // columns still owed by the block
    int               full_rows    [$];              // rows loaded across all 16 columns

    int err_count     = 0;
    int cycle_count   = 0;
    bit quiet         = 1'b0;    // no idling on either side while set
    bit sink_hold_req = 1'b0;    // ask the sink for one long hold-off

    sparse_fiber_times_matrix dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // 0 behaves as 1, anything above 16 as 16
    function automatic int active_width();
        if (cols_reg == 0) return 1;
        if (cols_reg > COLS) return COLS;
        return int'(cols_reg);
    endfunction

    function automatic bit row_ready(input int row);
        int k;
        for (k = 0; k < active_width(); k++) begin
            if (!mat_written[row][k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one accepted request to the predictor; a last nonzero queues the fiber.
    function automatic void accumulate_request(input logic op, input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col,
                                               input logic [VAL_W-1:0] val, input logic last);
        int          n;
        int          k;
        longint      prod;
        longint      s;
        t_col_result res;
        n = active_width();
        // row and column fields cannot reach past the 256 x 16 store
        if (op == OP_LOAD) begin
            mat_entry[row][col]   = val;
            mat_written[row][col] = 1'b1;
            return;
        end
        for (k = 0; k < n; k++) begin
            prod = longint'($signed(val)) * longint'($signed(mat_entry[row][k]));
            s    = col_acc[k] + prod;
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            col_acc[k] = s;
        end
        if (!last) return;
        for (k = 0; k < n; k++) begin
            res.col  = k[COL_W-1:0];
            res.sum  = col_acc[k][SUM_W-1:0];
            res.last = (k == n - 1);
            pending_cols.push_back(res);
        end
        // every accumulator clears, including columns beyond the current count
        for (k = 0; k < COLS; k++) col_acc[k] = 0;
    endfunction

    // Mostly random values, with the Q8.8 extremes and small values mixed in.
    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(15))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return VAL_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Any row whose columns in use are all loaded; otherwise a fully loaded row.
    function automatic logic [ROW_W-1:0] pick_row();
        int r;
        r = $urandom_range(ROWS - 1);
        if (row_ready(r)) return ROW_W'(r);
        return ROW_W'(full_rows[$urandom_range(full_rows.size() - 1)]);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: random idle gaps, then hold tvalid until accepted.
    // Drives at the falling edge, samples tready at the rising edge.
    // ------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [ROW_W-1:0] row,
                                input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
                                input logic last);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {4'b0000, val, col, row};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        accumulate_request(op, row, col, val, last);
    endtask

    // Stop offering requests, wait until every owed column has come out,
    // then give the MAC pipe time to finish work that produces no result.
    task automatic wait_idle(input int extra);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_cols.size() != 0) @(posedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic set_cols_in_use(input logic [CFG_W-1:0] width);
        wait_idle(DRAIN_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= width;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cols_reg     = width;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill a set of rows whose indexes toggle every row bit; row 0 holds the
    // largest entry, row 255 the most negative one. Loads carry random last marks.
    task automatic test_matrix_load();
        int rows [4];
        int i;
        int c;
        logic [VAL_W-1:0] v;
        rows = '{0, 255, 'h55, 'hAA};
        for (i = 0; i < 4; i++) begin
            for (c = 0; c < COLS; c++) begin
                if (rows[i] == 0)        v = VAL_MAX;
                else if (rows[i] == 255) v = VAL_MIN;
                else                     v = rand_value();
                send_request(OP_LOAD, ROW_W'(rows[i]), COL_W'(c), v, 1'($urandom_range(1)));
            end
            full_rows.push_back(rows[i]);
        end
    endtask

    // Reset width of 16 columns: largest products of both signs, a zero value,
    // a load that carries a last mark and so emits nothing.
    task automatic test_directed_fibers();
        send_request(OP_NZ, 8'd255, 4'd0, VAL_MIN, 1'b1);
        send_request(OP_NZ, 8'd0,   4'd0, VAL_MAX, 1'b0);
        send_request(OP_NZ, 8'd255, 4'd0, VAL_MAX, 1'b1);
        send_request(OP_NZ, 8'h55,  4'd0, 16'h0000, 1'b1);
        send_request(OP_LOAD, 8'h10, 4'hF, 16'h1234, 1'b1);
        send_request(OP_NZ, 8'hAA,  4'd7, 16'hFFFF, 1'b1);
    endtask

    // Column counts at and beyond the ends of the range: 0 acts as 1, 17 and 31 as 16.
    task automatic test_width_extremes();
        logic [CFG_W-1:0] widths [5];
        int i;
        widths = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16};
        for (i = 0; i < 5; i++) begin
            set_cols_in_use(widths[i]);
            send_request(OP_NZ, pick_row(), 4'd0, rand_value(), 1'b0);
            send_request(OP_NZ, pick_row(), 4'd0, rand_value(), 1'b1);
        end
    endtask

    // Column count changed in the middle of a fiber, down and then up.
    // Stale sums in columns past the new count must still be cleared on emit.
    task automatic test_width_change_mid_fiber();
        set_cols_in_use(5'd16);
        send_request(OP_NZ, 8'h55, 4'd0, rand_value(), 1'b0);
        send_request(OP_NZ, 8'hAA, 4'd0, rand_value(), 1'b0);
        set_cols_in_use(5'd4);
        send_request(OP_NZ, 8'd0, 4'd0, rand_value(), 1'b1);
        set_cols_in_use(5'd16);
        send_request(OP_NZ, 8'd255, 4'd0, rand_value(), 1'b1);
        set_cols_in_use(5'd3);
        send_request(OP_NZ, 8'hAA, 4'd0, rand_value(), 1'b0);
        set_cols_in_use(5'd9);
        send_request(OP_NZ, 8'h55, 4'd0, rand_value(), 1'b1);
    endtask

    // Column 0 gains +2^30 per nonzero and column 1 loses about as much, so
    // both sums run far past 32 bits; a few opposite products then pull
    // them back.
    task automatic test_saturation();
        int i;
        set_cols_in_use(5'd2);
        send_request(OP_LOAD, 8'd3, 4'd0, VAL_MIN, 1'b0);
        send_request(OP_LOAD, 8'd3, 4'd1, VAL_MAX, 1'b0);
        for (i = 0; i < 12; i++) send_request(OP_NZ, 8'd3, 4'd0, VAL_MIN, 1'b0);
        for (i = 0; i < 3; i++)  send_request(OP_NZ, 8'd3, 4'd0, VAL_MAX, i == 2);
    endtask

    // The sink holds off for a long stretch while full-width fibers keep
    // coming, so the output side backs up and the input stalls.
    task automatic test_output_stall();
        int i;
        set_cols_in_use(5'd16);
        sink_hold_req = 1'b1;
        for (i = 0; i < 12; i++) send_request(OP_NZ, pick_row(), 4'd0, rand_value(), 1'b1);
    endtask

    // Well-formed fibers of random length with random content, loads mixed in.
    // One phase runs with no idling on either side.
    task automatic test_random_fibers(input int n_items);
        logic [CFG_W-1:0] widths [6];
        int per_phase;
        int ph;
        int sent;
        int len;
        int i;
        widths = '{5'd16, 5'd1, 5'd0, 5'd31, CFG_W'($urandom_range(2, 15)),
                   CFG_W'($urandom_range(1, 16))};
        per_phase = n_items / 6;
        for (ph = 0; ph < 6; ph++) begin
            set_cols_in_use(widths[ph]);
            quiet = (ph == 3);
            sent  = 0;
            while (sent < per_phase) begin
                if ($urandom_range(99) < 15) begin
                    send_request(OP_LOAD, ROW_W'($urandom_range(ROWS - 1)),
                                 COL_W'($urandom_range(COLS - 1)), rand_value(),
                                 1'($urandom_range(1)));
                    sent++;
                end else begin
                    len = $urandom_range(1, 5);
                    for (i = 0; i < len; i++) begin
                        send_request(OP_NZ, pick_row(), COL_W'($urandom_range(COLS - 1)),
                                     rand_value(), i == len - 1);
                        sent++;
                    end
                end
            end
            quiet = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sink: random tready, a counted long hold-off on request, none when quiet
    // ------------------------------------------------------------------
    initial begin : sink_ready
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                hold_left     = SINK_HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (quiet) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted column against the oldest one owed
    // ------------------------------------------------------------------
    t_col_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_cols.size() == 0) begin
                $display("%0t ERROR: unexpected result col %0d sum %h last %b", $time,
                         m_axis_tdata[3:0], m_axis_tdata[43:4], m_axis_tlast);
                err_count++;
            end else begin
                want = pending_cols.pop_front();
                if (m_axis_tdata[3:0] !== want.col) begin
                    $display("%0t ERROR: out_col expected %0d got %0d", $time,
                             want.col, m_axis_tdata[3:0]);
                    err_count++;
                end
                if (m_axis_tdata[43:4] !== want.sum) begin
                    $display("%0t ERROR: col %0d out_sum expected %h got %h", $time,
                             want.col, want.sum, m_axis_tdata[43:4]);
                    err_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t ERROR: col %0d out_last expected %b got %b", $time,
                             want.col, want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_matrix_load();
        test_directed_fibers();
        test_width_extremes();
        test_width_change_mid_fiber();
        test_saturation();
        test_output_stall();
        test_random_fibers(RANDOM_ITEMS);

        wait_idle(DRAIN_CYCLES);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sftm_pkg.sv
rtl/sftm_ctrl.sv
rtl/sftm_dp.sv
rtl/sparse_fiber_times_matrix.sv
sim/tb_sparse_fiber_times_matrix.sv
